>>> src/rotated_page_framebuffer_defines.svh
// ----------------------------------------------------------------------------
// rotated_page_framebuffer_defines
// Assertion macros shared by the framebuffer RTL. Define ASSERT_OFF to drop
// every check.
// ----------------------------------------------------------------------------
`ifndef ROTATED_PAGE_FRAMEBUFFER_DEFINES_SVH
`define ROTATED_PAGE_FRAMEBUFFER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, sampled on clk, quiet while rst is high
`define RPF_ASSERT_IMPL(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("rpf: same-cycle check failed");

// next-cycle implication, sampled on clk, quiet while rst is high
`define RPF_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("rpf: next-cycle check failed");

`else

`define RPF_ASSERT_IMPL(label, cond, expr)
`define RPF_ASSERT_NEXT(label, cond, expr)

`endif

`endif

>>> src/rpf_pkg.sv
// ----------------------------------------------------------------------------
// rpf_pkg
// Shared constants, codes and types of the rotated page framebuffer.
// ----------------------------------------------------------------------------
package rpf_pkg;

  // default panel geometry
  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 128;

  // window coordinate width
  localparam int WIN_W = 12;
  typedef logic signed [WIN_W-1:0] coord_t;

  // empty window marks
  localparam coord_t EMPTY_LOW  = 12'sd1024;
  localparam coord_t EMPTY_HIGH = -12'sd1;

  // operation codes
  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  // color codes
  localparam logic [1:0] COLOR_BLACK  = 2'd0;
  localparam logic [1:0] COLOR_WHITE  = 2'd1;
  localparam logic [1:0] COLOR_INVERT = 2'd2;
  localparam logic [1:0] COLOR_NONE   = 2'd3;

  // rotation codes, quarter turns
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // physical location of one draw
  typedef struct packed {
    logic       hit;      // inside the rotated panel
    coord_t     px;       // physical column
    coord_t     py;       // physical row
    logic [2:0] bit_sel;  // bit within the page byte
  } loc_t;

endpackage

>>> src/rpf_ram.sv
// ----------------------------------------------------------------------------
// rpf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/rpf_xform.sv
// ----------------------------------------------------------------------------
// rpf_xform
// Bounds check, quarter-turn rotation and page byte address of one pixel.
// ----------------------------------------------------------------------------
module rpf_xform #(
  parameter int PANEL_WIDTH  = rpf_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = rpf_pkg::PANEL_HEIGHT_DEF,
  parameter int AW           = 11
) (
  input  logic signed [10:0] pos_x,
  input  logic signed [10:0] pos_y,
  input  logic [1:0]         rotation,
  output rpf_pkg::loc_t      loc,
  output logic [AW-1:0]      idx
);

  localparam rpf_pkg::coord_t W_C = rpf_pkg::WIN_W'(PANEL_WIDTH);
  localparam rpf_pkg::coord_t H_C = rpf_pkg::WIN_W'(PANEL_HEIGHT);

  rpf_pkg::coord_t x12, y12, lw, lh, px, py;
  logic [8:0]      page;

  always_comb begin
    x12 = {pos_x[10], pos_x};
    y12 = {pos_y[10], pos_y};

    // odd turns swap logical width and height
    lw = rotation[0] ? H_C : W_C;
    lh = rotation[0] ? W_C : H_C;

    // quarter-turn mapping to physical column and row
    unique case (rotation)
      rpf_pkg::ROT_90: begin
        px = W_C - 12'sd1 - y12;
        py = x12;
      end
      rpf_pkg::ROT_180: begin
        px = W_C - 12'sd1 - x12;
        py = H_C - 12'sd1 - y12;
      end
      rpf_pkg::ROT_270: begin
        px = y12;
        py = H_C - 12'sd1 - x12;
      end
      default: begin
        px = x12;
        py = y12;
      end
    endcase

    page = py[11:3];

    loc.hit     = !x12[11] && (x12 < lw) && !y12[11] && (y12 < lh);
    loc.px      = px;
    loc.py      = py;
    loc.bit_sel = py[2:0];

    // column plus page times panel width
    idx = AW'(px) + AW'(page) * AW'(PANEL_WIDTH);
  end

endmodule

>>> src/rotated_page_framebuffer.sv
// ----------------------------------------------------------------------------
// rotated_page_framebuffer
// Monochrome page-organized framebuffer with rotation and dirty window.
// ----------------------------------------------------------------------------
// The block handles one command at a time. The store is one RAM with a
// registered read, so a draw that writes the store or a read of an
// in-range byte issues the read, then writes back the modified byte or
// captures the read byte, then hands the response to the output register
// once it is free; an out-of-bounds draw, a draw with color three, a read
// beyond the store and a mark-flushed skip the store access. Clear all
// walks the store one byte a cycle, then hands its response over. After
// reset the same clearing pass runs over all PANEL_WIDTH * ceil(PANEL_HEIGHT
// / 8) bytes (2048 at the default 128 x 128) with cmd_ready low; rotation
// writes are taken at any time. A new command is accepted while the
// previous response still waits in the output register.
// ----------------------------------------------------------------------------
`include "rotated_page_framebuffer_defines.svh"

module rotated_page_framebuffer #(
  parameter int PANEL_WIDTH  = rpf_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = rpf_pkg::PANEL_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_enable,
  input  logic [1:0]         cfg_write_data,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic [1:0]         operation,
  input  logic signed [10:0] pos_x,
  input  logic signed [10:0] pos_y,
  input  logic [1:0]         color,
  input  logic [10:0]        byte_address,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [7:0]         read_data,
  output logic               pixel_written,
  output logic signed [11:0] win_left,
  output logic signed [11:0] win_top,
  output logic signed [11:0] win_right,
  output logic signed [11:0] win_bottom
);

  localparam int STORE_BYTES = PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8);
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int CMPW        = ((AW > 11) ? AW : 11) + 1;

  localparam rpf_pkg::coord_t FULL_RIGHT  = rpf_pkg::WIN_W'(PANEL_WIDTH - 1);
  localparam rpf_pkg::coord_t FULL_BOTTOM = rpf_pkg::WIN_W'(PANEL_HEIGHT - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_ACCESS, S_DONE} state_t;

  state_t          state;
  logic [1:0]      rotation;
  logic [AW-1:0]   clr_addr;
  logic            clr_op;
  logic            cur_read;
  logic [1:0]      cur_color;
  logic [AW-1:0]   cur_idx;
  logic [2:0]      cur_bit;
  logic [7:0]      res_data;
  logic            res_written;
  rpf_pkg::coord_t dirty_left, dirty_top, dirty_right, dirty_bottom;

  rpf_pkg::loc_t   loc;
  logic [AW-1:0]   loc_idx;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;
  logic [7:0]      mask, modified;
  logic            rsp_free;
  logic            draw_store;
  logic            read_in;

  // coordinate transform of the incoming beat
  rpf_xform #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .AW           (AW)
  ) u_xform (
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .rotation (rotation),
    .loc      (loc),
    .idx      (loc_idx)
  );

  // pixel store
  rpf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmd_ready = (state == S_IDLE);

  // store access and bit update
  always_comb begin
    ram_raddr  = (operation == rpf_pkg::OP_READ) ? AW'(byte_address) : loc_idx;
    mask       = 8'h01 << cur_bit;
    case (cur_color)
      rpf_pkg::COLOR_BLACK: modified = ram_rdata & ~mask;
      rpf_pkg::COLOR_WHITE: modified = ram_rdata | mask;
      default:              modified = ram_rdata ^ mask;
    endcase
    ram_we     = (state == S_CLEAR) || ((state == S_ACCESS) && !cur_read);
    ram_waddr  = (state == S_CLEAR) ? clr_addr : cur_idx;
    ram_wdata  = (state == S_CLEAR) ? 8'h00 : modified;
    rsp_free   = !rsp_valid || rsp_ready;
    draw_store = loc.hit && (color != rpf_pkg::COLOR_NONE);
    read_in    = CMPW'(byte_address) < CMPW'(STORE_BYTES);
  end

  // sequencer, dirty window and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      rotation     <= rpf_pkg::ROT_0;
      clr_addr     <= '0;
      clr_op       <= 1'b0;
      dirty_left   <= '0;
      dirty_top    <= '0;
      dirty_right  <= FULL_RIGHT;
      dirty_bottom <= FULL_BOTTOM;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        rotation <= cfg_write_data;
      end
      // output register drains; in S_DONE it may refill in the same cycle
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        // zero the store one byte a cycle
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(STORE_BYTES - 1)) begin
            state <= clr_op ? S_DONE : S_IDLE;
          end
        end

        // take a command beat
        S_IDLE: begin
          if (cmd_valid) begin
            res_data    <= 8'h00;
            res_written <= 1'b0;
            unique case (operation)
              rpf_pkg::OP_DRAW: begin
                cur_read  <= 1'b0;
                cur_color <= color;
                cur_idx   <= loc_idx;
                cur_bit   <= loc.bit_sel;
                if (loc.hit) begin
                  if (loc.px < dirty_left)   dirty_left   <= loc.px;
                  if (loc.py < dirty_top)    dirty_top    <= loc.py;
                  if (loc.px > dirty_right)  dirty_right  <= loc.px;
                  if (loc.py > dirty_bottom) dirty_bottom <= loc.py;
                end
                state <= draw_store ? S_ACCESS : S_DONE;
              end
              rpf_pkg::OP_READ: begin
                cur_read <= 1'b1;
                state    <= read_in ? S_ACCESS : S_DONE;
              end
              rpf_pkg::OP_CLEAR: begin
                dirty_left   <= '0;
                dirty_top    <= '0;
                dirty_right  <= FULL_RIGHT;
                dirty_bottom <= FULL_BOTTOM;
                clr_addr     <= '0;
                clr_op       <= 1'b1;
                state        <= S_CLEAR;
              end
              rpf_pkg::OP_FLUSH: begin
                dirty_left   <= rpf_pkg::EMPTY_LOW;
                dirty_top    <= rpf_pkg::EMPTY_LOW;
                dirty_right  <= rpf_pkg::EMPTY_HIGH;
                dirty_bottom <= rpf_pkg::EMPTY_HIGH;
                state        <= S_DONE;
              end
            endcase
          end
        end

        // read data is back: capture it or write the modified byte
        S_ACCESS: begin
          if (cur_read) begin
            res_data <= ram_rdata;
          end else begin
            res_written <= 1'b1;
          end
          state <= S_DONE;
        end

        // hand the result over once the output register is free
        S_DONE: begin
          if (rsp_free) begin
            rsp_valid     <= 1'b1;
            read_data     <= res_data;
            pixel_written <= res_written;
            win_left      <= dirty_left;
            win_top       <= dirty_top;
            win_right     <= dirty_right;
            win_bottom    <= dirty_bottom;
            state         <= S_IDLE;
          end
        end
      endcase
    end
  end

  // store writes come only from the clearing walk or a draw write-back
  `RPF_ASSERT_IMPL(a_write_source, ram_we, state == S_CLEAR || (state == S_ACCESS && !cur_read))
  // one command in flight
  `RPF_ASSERT_NEXT(a_one_in_flight, cmd_valid && cmd_ready, !cmd_ready)
  // a stored pixel always lies inside a non-empty window
  `RPF_ASSERT_IMPL(a_window_covers, rsp_valid && pixel_written,
                   win_left <= win_right && win_top <= win_bottom)

endmodule
